[rtl/rtprb_pkg.sv]
// ----------------------------------------------------------------------------
// RTP reorder and playout buffer package
// Shared types and constants for the jitter buffer and its entry store.
// ----------------------------------------------------------------------------
package rtprb_pkg;

    // Input function codes
    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_INSERT   = 2'd0;
    localparam logic [1:0] KIND_RELEASE  = 2'd1;
    localparam logic [1:0] KIND_NOTHING  = 2'd2;

    // Insert status codes
    localparam logic [1:0] STAT_IN_ORDER  = 2'd0;
    localparam logic [1:0] STAT_OUT_ORDER = 2'd1;
    localparam logic [1:0] STAT_DUPLICATE = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd3;

    // Configuration register indexes
    localparam logic [3:0] CFG_BUFFER_LIMIT   = 4'd0;
    localparam logic [3:0] CFG_PREBUFFER_SPAN = 4'd1;

    // Reset values of the configuration registers
    localparam logic [6:0]  LIMIT_RESET = 7'd64;
    localparam logic [22:0] SPAN_RESET  = 23'd180000;

    typedef struct packed {
        logic        func;
        logic [15:0] seq_number;
        logic [31:0] media_time;
        logic [15:0] payload_handle;
        logic [31:0] now;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  insert_status;
        logic [15:0] out_handle;
        logic [15:0] out_seq;
        logic [31:0] out_time;
        logic        last;
        logic [31:0] received_count;
        logic [31:0] duplicate_count;
        logic [31:0] reorder_count;
        logic [31:0] overflow_count;
        logic [6:0]  fill_level;
    } out_item_t;

    // One stored packet descriptor
    typedef struct packed {
        logic [15:0] seq;
        logic [31:0] media_time;
        logic [15:0] handle;
    } entry_t;

    // Request from the controller to the entry store, logical indexes
    typedef struct packed {
        logic       rd_en;
        logic [6:0] rd_idx;
        logic       wr_en;
        logic [6:0] wr_idx;
        logic       pop;
    } ram_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_WRITE,
        ST_CHECK,
        ST_CHECK_FIRST,
        ST_CHECK_LAST,
        ST_EMIT_INSERT,
        ST_TICK_NONE,
        ST_REL_READ,
        ST_REL_COMPARE,
        ST_REL_FLUSH
    } state_t;

endpackage

[rtl/rtprb_entry_ram.sv]
// ----------------------------------------------------------------------------
// Entry store
// Ring buffer of packet descriptors addressed by logical position from the
// head. One synchronous read port with registered data and one write port.
// ----------------------------------------------------------------------------
module rtprb_entry_ram
    import rtprb_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  ram_req_t req,
    input  entry_t   wr_data,
    output entry_t   rd_data
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [AW:0] CAP_W = (AW + 1)'(CAPACITY);

    entry_t        mem [CAPACITY];
    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    entry_t        rd_data_reg;

    // Map a logical position onto a physical address behind the head.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [6:0] idx);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, idx[AW-1:0]};
        if (sum >= CAP_W)
        begin
            sum = sum - CAP_W;
        end
        return sum[AW-1:0];
    endfunction

    assign rd_addr = phys(head_reg, req.rd_idx);
    assign wr_addr = phys(head_reg, req.wr_idx);

    // Head advances when the front entry is released.
    always_comb
    begin
        head_next = head_reg;
        if (req.pop)
        begin
            head_next = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
        end
    end

    // Storage array with registered read data.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/rtp_reorder_playout_buffer.sv]
// ----------------------------------------------------------------------------
// RTP reorder and playout buffer
// Keeps packet descriptors sorted by sequence number, gathers a prebuffer
// span, then releases due packets on each time tick.
// ----------------------------------------------------------------------------
// An arrival searches the held entries (at most CAPACITY, 64 by default); when
// it goes out of order the entries above its insert point shift up first, and
// an overflow skips both. A tick walks the due packets through the single-port
// read of the entry store, or reports nothing while prebuffering or when none
// is due. One item is worked at a time. Reset clears all counters, the fill
// count and the play offset and enters prebuffering; stored entries are not
// cleared, so there is no clearing pass.
module rtp_reorder_playout_buffer
    import rtprb_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [22:0] cfg_data
);

    state_t      state_reg, state_next;
    logic [6:0]  count_reg, count_next;
    logic        prebuf_reg, prebuf_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] rcv_reg, rcv_next;
    logic [31:0] dup_reg, dup_next;
    logic [31:0] ooo_reg, ooo_next;
    logic [31:0] ovf_reg, ovf_next;
    logic [6:0]  limit_reg;
    logic [22:0] span_reg;
    in_item_t    in_reg, in_next;
    logic [1:0]  status_reg, status_next;
    logic [6:0]  pos_reg, pos_next;
    logic [6:0]  iss_reg, iss_next;
    logic [6:0]  cmp_idx_reg, cmp_idx_next;
    logic [6:0]  left_reg, left_next;
    logic        rd_vld_reg, rd_vld_next;
    logic [31:0] first_reg, first_next;
    entry_t      pend_reg, pend_next;
    logic [6:0]  pend_fill_reg, pend_fill_next;
    logic        have_reg, have_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    ram_req_t    ram_req;
    entry_t      ram_wr_data;
    entry_t      ram_rd_data;

    logic [6:0]  lim_eff;
    logic        out_free;
    logic [31:0] span_diff;
    logic [31:0] due_time;

    rtprb_entry_ram #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .wr_data (ram_wr_data),
        .rd_data (ram_rd_data)
    );

    // A limit above the store size acts as the store size.
    assign lim_eff   = (limit_reg > 7'(CAPACITY)) ? 7'(CAPACITY) : limit_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign span_diff = ram_rd_data.media_time - first_reg;
    assign due_time  = ram_rd_data.media_time + offset_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
            span_reg  <= SPAN_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_BUFFER_LIMIT)
            begin
                limit_reg <= cfg_data[6:0];
            end
            else if (cfg_index == CFG_PREBUFFER_SPAN)
            begin
                span_reg <= cfg_data;
            end
        end
    end

    // Control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            prebuf_reg    <= 1'b1;
            offset_reg    <= '0;
            rcv_reg       <= '0;
            dup_reg       <= '0;
            ooo_reg       <= '0;
            ovf_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            prebuf_reg    <= prebuf_next;
            offset_reg    <= offset_next;
            rcv_reg       <= rcv_next;
            dup_reg       <= dup_next;
            ooo_reg       <= ooo_next;
            ovf_reg       <= ovf_next;
            rd_vld_reg    <= rd_vld_next;
            have_reg      <= have_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_reg        <= in_next;
        status_reg    <= status_next;
        pos_reg       <= pos_next;
        iss_reg       <= iss_next;
        cmp_idx_reg   <= cmp_idx_next;
        left_reg      <= left_next;
        first_reg     <= first_next;
        pend_reg      <= pend_next;
        pend_fill_reg <= pend_fill_next;
        out_reg       <= out_next;
    end

    // Sequencer: search, shift, insert, prebuffer check and release walk
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        prebuf_next    = prebuf_reg;
        offset_next    = offset_reg;
        rcv_next       = rcv_reg;
        dup_next       = dup_reg;
        ooo_next       = ooo_reg;
        ovf_next       = ovf_reg;
        in_next        = in_reg;
        status_next    = status_reg;
        pos_next       = pos_reg;
        iss_next       = iss_reg;
        cmp_idx_next   = cmp_idx_reg;
        left_next      = left_reg;
        rd_vld_next    = 1'b0;
        first_next     = first_reg;
        pend_next      = pend_reg;
        pend_fill_next = pend_fill_reg;
        have_next      = have_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        ram_req        = '0;
        ram_wr_data    = ram_rd_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_next = in_data;
                    if (in_data.func == FUNC_ARRIVAL)
                    begin
                        rcv_next = rcv_reg + 1'b1;
                        if (count_reg >= lim_eff)
                        begin
                            ovf_next    = ovf_reg + 1'b1;
                            status_next = STAT_OVERFLOW;
                            state_next  = ST_CHECK;
                        end
                        else if (count_reg == '0)
                        begin
                            pos_next    = '0;
                            status_next = STAT_IN_ORDER;
                            state_next  = ST_WRITE;
                        end
                        else
                        begin
                            iss_next   = '0;
                            state_next = ST_SEARCH;
                        end
                    end
                    else
                    begin
                        have_next  = 1'b0;
                        state_next = prebuf_reg ? ST_TICK_NONE : ST_REL_READ;
                    end
                end
            end

            ST_SEARCH:
            begin
                // Reads stream one per cycle; each compare uses the registered data of the read before.
                if (iss_reg < count_reg)
                begin
                    ram_req.rd_en = 1'b1;
                    ram_req.rd_idx = iss_reg;
                    iss_next       = iss_reg + 1'b1;
                    cmp_idx_next   = iss_reg;
                    rd_vld_next    = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (ram_rd_data.seq < in_reg.seq_number)
                    begin
                        if (cmp_idx_reg == count_reg - 1'b1)
                        begin
                            pos_next    = count_reg;
                            status_next = STAT_IN_ORDER;
                            rd_vld_next = 1'b0;
                            state_next  = ST_WRITE;
                        end
                    end
                    else if (ram_rd_data.seq == in_reg.seq_number)
                    begin
                        dup_next    = dup_reg + 1'b1;
                        status_next = STAT_DUPLICATE;
                        rd_vld_next = 1'b0;
                        state_next  = ST_CHECK;
                    end
                    else
                    begin
                        ooo_next    = ooo_reg + 1'b1;
                        pos_next    = cmp_idx_reg;
                        status_next = STAT_OUT_ORDER;
                        iss_next    = count_reg - 1'b1;
                        left_next   = count_reg - cmp_idx_reg;
                        rd_vld_next = 1'b0;
                        state_next  = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT:
            begin
                // Move entries up by one from the tail down to the insert point.
                if (left_reg != '0)
                begin
                    ram_req.rd_en  = 1'b1;
                    ram_req.rd_idx = iss_reg;
                    iss_next       = iss_reg - 1'b1;
                    left_next      = left_reg - 1'b1;
                    cmp_idx_next   = iss_reg;
                    rd_vld_next    = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    ram_req.wr_en  = 1'b1;
                    ram_req.wr_idx = cmp_idx_reg + 1'b1;
                    ram_wr_data    = ram_rd_data;
                end
                if (left_reg == '0 && !rd_vld_reg)
                begin
                    state_next = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                ram_req.wr_en          = 1'b1;
                ram_req.wr_idx         = pos_reg;
                ram_wr_data.seq        = in_reg.seq_number;
                ram_wr_data.media_time = in_reg.media_time;
                ram_wr_data.handle     = in_reg.payload_handle;
                count_next             = count_reg + 1'b1;
                state_next             = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (!prebuf_reg || count_reg == '0)
                begin
                    state_next = ST_EMIT_INSERT;
                end
                else
                begin
                    ram_req.rd_en  = 1'b1;
                    ram_req.rd_idx = '0;
                    state_next     = ST_CHECK_FIRST;
                end
            end

            ST_CHECK_FIRST:
            begin
                first_next     = ram_rd_data.media_time;
                ram_req.rd_en  = 1'b1;
                ram_req.rd_idx = count_reg - 1'b1;
                state_next     = ST_CHECK_LAST;
            end

            ST_CHECK_LAST:
            begin
                // A negative span never ends prebuffering.
                if (!span_diff[31] && span_diff >= {9'b0, span_reg})
                begin
                    prebuf_next = 1'b0;
                    offset_next = in_reg.now - first_reg;
                end
                state_next = ST_EMIT_INSERT;
            end

            ST_EMIT_INSERT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next                 = '0;
                    out_next.kind            = KIND_INSERT;
                    out_next.insert_status   = status_reg;
                    out_next.last            = 1'b1;
                    out_next.received_count  = rcv_reg;
                    out_next.duplicate_count = dup_reg;
                    out_next.reorder_count   = ooo_reg;
                    out_next.overflow_count  = ovf_reg;
                    out_next.fill_level      = count_reg;
                    state_next               = ST_IDLE;
                end
            end

            ST_TICK_NONE:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next                 = '0;
                    out_next.kind            = KIND_NOTHING;
                    out_next.last            = 1'b1;
                    out_next.received_count  = rcv_reg;
                    out_next.duplicate_count = dup_reg;
                    out_next.reorder_count   = ooo_reg;
                    out_next.overflow_count  = ovf_reg;
                    out_next.fill_level      = count_reg;
                    state_next               = ST_IDLE;
                end
            end

            ST_REL_READ:
            begin
                ram_req.rd_en  = 1'b1;
                ram_req.rd_idx = '0;
                state_next     = ST_REL_COMPARE;
            end

            ST_REL_COMPARE:
            begin
                // A held packet goes out once we know whether another follows.
                if (due_time <= in_reg.now)
                begin
                    if (!have_reg || out_free)
                    begin
                        if (have_reg)
                        begin
                            out_valid_next           = 1'b1;
                            out_next                 = '0;
                            out_next.kind            = KIND_RELEASE;
                            out_next.out_handle      = pend_reg.handle;
                            out_next.out_seq         = pend_reg.seq;
                            out_next.out_time        = pend_reg.media_time;
                            out_next.received_count  = rcv_reg;
                            out_next.duplicate_count = dup_reg;
                            out_next.reorder_count   = ooo_reg;
                            out_next.overflow_count  = ovf_reg;
                            out_next.fill_level      = pend_fill_reg;
                        end
                        pend_next      = ram_rd_data;
                        have_next      = 1'b1;
                        ram_req.pop    = 1'b1;
                        count_next     = count_reg - 1'b1;
                        pend_fill_next = count_reg - 1'b1;
                        if (count_reg == 7'd1)
                        begin
                            prebuf_next = 1'b1;
                            state_next  = ST_REL_FLUSH;
                        end
                        else
                        begin
                            state_next = ST_REL_READ;
                        end
                    end
                end
                else
                begin
                    state_next = have_reg ? ST_REL_FLUSH : ST_TICK_NONE;
                end
            end

            ST_REL_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_next                 = '0;
                    out_next.kind            = KIND_RELEASE;
                    out_next.out_handle      = pend_reg.handle;
                    out_next.out_seq         = pend_reg.seq;
                    out_next.out_time        = pend_reg.media_time;
                    out_next.last            = 1'b1;
                    out_next.received_count  = rcv_reg;
                    out_next.duplicate_count = dup_reg;
                    out_next.reorder_count   = ooo_reg;
                    out_next.overflow_count  = ovf_reg;
                    out_next.fill_level      = pend_fill_reg;
                    have_next                = 1'b0;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The fill count never exceeds the store size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 7'(CAPACITY))
        else $error("fill count exceeds capacity");

    // Playout mode always has something held.
    assert property (@(posedge clk) disable iff (!rst_n)
        !prebuf_reg |-> count_reg != '0)
        else $error("playout mode with empty store");

    // The shift never reads the entry it writes in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.rd_en && ram_req.wr_en) |-> ram_req.rd_idx != ram_req.wr_idx)
        else $error("store read and write collide");

    // A release pops only while the output can take the held packet.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.pop && have_reg) |-> out_valid_next)
        else $error("release popped without emitting");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// RTP reorder and playout buffer testbench
// Drives arrivals and ticks through the valid/ready input channel. A scoreboard
// keeps its own copy of the sorted packet store and predicts every result.
// Each transaction on the output is compared field by field with the oldest
// expectation.
// ----------------------------------------------------------------------------
module tb_top;
    import rtprb_pkg::*;

    localparam int DEPTH     = 64;
    localparam int WD_LIMIT  = 20000;
    localparam int LONG_HOLD = 600;

    // Scoreboard: a behavioral copy of the jitter buffer and its expected results.
    class playout_scoreboard;
        logic [15:0] seq_q[$];
        logic [31:0] time_q[$];
        logic [15:0] handle_q[$];
        bit          prebuf;
        logic [31:0] offset;
        logic [31:0] n_recv, n_dup, n_reorder, n_ovf;
        logic [6:0]  limit_reg;
        logic [22:0] span_reg;
        out_item_t   pending[$];
        int          errors;

        function new();
            prebuf    = 1'b1;
            offset    = '0;
            n_recv    = '0;
            n_dup     = '0;
            n_reorder = '0;
            n_ovf     = '0;
            limit_reg = LIMIT_RESET;
            span_reg  = SPAN_RESET;
            errors    = 0;
        endfunction

        function void write_reg(logic [3:0] idx, logic [22:0] val);
            if (idx == CFG_BUFFER_LIMIT)
                limit_reg = val[6:0];
            else if (idx == CFG_PREBUFFER_SPAN)
                span_reg = val;
        endfunction

        function out_item_t blank(logic [1:0] k);
            out_item_t r;
            r = '0;
            r.kind            = k;
            r.received_count  = n_recv;
            r.duplicate_count = n_dup;
            r.reorder_count   = n_reorder;
            r.overflow_count  = n_ovf;
            r.fill_level      = 7'(seq_q.size());
            return r;
        endfunction

        // Works out the results of one accepted input transaction.
        function void note_input(in_item_t it);
            int          lim;
            int          pos;
            logic [1:0]  status;
            logic [31:0] diff;
            out_item_t   r;
            int          n;
            if (it.func == FUNC_ARRIVAL)
            begin
                lim = (limit_reg > DEPTH) ? DEPTH : limit_reg;
                n_recv++;
                if (seq_q.size() >= lim)
                begin
                    n_ovf++;
                    status = STAT_OVERFLOW;
                end
                else
                begin
                    pos = 0;
                    while (pos < seq_q.size() && seq_q[pos] < it.seq_number)
                        pos++;
                    if (pos < seq_q.size() && seq_q[pos] == it.seq_number)
                    begin
                        n_dup++;
                        status = STAT_DUPLICATE;
                    end
                    else
                    begin
                        if (pos < seq_q.size())
                        begin
                            n_reorder++;
                            status = STAT_OUT_ORDER;
                        end
                        else
                            status = STAT_IN_ORDER;
                        seq_q.insert(pos, it.seq_number);
                        time_q.insert(pos, it.media_time);
                        handle_q.insert(pos, it.payload_handle);
                    end
                end
                // Span test after every arrival while prebuffering.
                if (prebuf && seq_q.size() > 0)
                begin
                    diff = time_q[$] - time_q[0];
                    if (!diff[31] && diff >= {9'd0, span_reg})
                    begin
                        prebuf = 1'b0;
                        offset = it.now - time_q[0];
                    end
                end
                r = blank(KIND_INSERT);
                r.insert_status = status;
                r.last = 1'b1;
                pending.push_back(r);
            end
            else
            begin
                n = 0;
                if (!prebuf)
                begin
                    while (seq_q.size() > 0 && (time_q[0] + offset) <= it.now)
                    begin
                        r = '0;
                        r.out_seq    = seq_q.pop_front();
                        r.out_time   = time_q.pop_front();
                        r.out_handle = handle_q.pop_front();
                        if (seq_q.size() == 0)
                            prebuf = 1'b1;
                        r.kind            = KIND_RELEASE;
                        r.received_count  = n_recv;
                        r.duplicate_count = n_dup;
                        r.reorder_count   = n_reorder;
                        r.overflow_count  = n_ovf;
                        r.fill_level      = 7'(seq_q.size());
                        pending.push_back(r);
                        n++;
                    end
                end
                if (n == 0)
                begin
                    r = blank(KIND_NOTHING);
                    r.last = 1'b1;
                    pending.push_back(r);
                end
                else
                    pending[$].last = 1'b1;
            end
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
            errors++;
        endfunction

        // Compares one output transaction with the oldest expectation.
        function void check_result(out_item_t got);
            out_item_t w;
            if (pending.size() == 0)
            begin
                $display("MISMATCH unexpected result transaction");
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.kind != w.kind) report("kind", got.kind, w.kind);
            if (got.insert_status != w.insert_status)
                report("insert_status", got.insert_status, w.insert_status);
            if (got.out_handle != w.out_handle)
                report("out_handle", got.out_handle, w.out_handle);
            if (got.out_seq != w.out_seq) report("out_seq", got.out_seq, w.out_seq);
            if (got.out_time != w.out_time) report("out_time", got.out_time, w.out_time);
            if (got.last != w.last) report("last", got.last, w.last);
            if (got.received_count != w.received_count)
                report("received_count", got.received_count, w.received_count);
            if (got.duplicate_count != w.duplicate_count)
                report("duplicate_count", got.duplicate_count, w.duplicate_count);
            if (got.reorder_count != w.reorder_count)
                report("reorder_count", got.reorder_count, w.reorder_count);
            if (got.overflow_count != w.overflow_count)
                report("overflow_count", got.overflow_count, w.overflow_count);
            if (got.fill_level != w.fill_level)
                report("fill_level", got.fill_level, w.fill_level);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_index;
    logic [22:0] cfg_data;

    playout_scoreboard sb;
    bit          idle_enabled;
    bit          hold_output;
    bit          running;
    int          quiet_cycles;
    logic [31:0] clock_now;
    logic [15:0] next_seq;
    logic [31:0] next_ts;

    rtp_reorder_playout_buffer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Sends one item and waits for its transaction, with random idle before it.
    // Valid stays high between back-to-back items and drops only for idling or in drain().
    task automatic send_item(input in_item_t it);
        if (idle_enabled && $urandom_range(3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_input(it);
    endtask

    task automatic send_arrival(input logic [15:0] s, input logic [31:0] t,
                                input logic [15:0] h, input logic [31:0] nw);
        in_item_t it;
        it = '0;
        it.func           = FUNC_ARRIVAL;
        it.seq_number     = s;
        it.media_time     = t;
        it.payload_handle = h;
        it.now            = nw;
        send_item(it);
    endtask

    // Ticks carry random content in the unused fields.
    task automatic send_tick(input logic [31:0] nw);
        in_item_t it;
        it.func           = FUNC_TICK;
        it.seq_number     = 16'($urandom);
        it.media_time     = $urandom;
        it.payload_handle = 16'($urandom);
        it.now            = nw;
        send_item(it);
    endtask

    // Waits for all expected results, then lets the block settle.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [3:0] idx, input logic [22:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One random item: mostly a well-formed stream with jitter and reordering.
    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            next_seq = next_seq + 16'd1;
            next_ts  = next_ts + $urandom_range(0, 6000);
            clock_now = clock_now + $urandom_range(0, 4000);
            send_arrival(16'(next_seq + $urandom_range(0, 4) - 16'd2),
                         next_ts, 16'($urandom), clock_now);
        end
        else if (pick < 85)
        begin
            clock_now = clock_now + $urandom_range(0, 12000);
            send_tick(clock_now);
        end
        else if (pick < 95)
            send_arrival(16'($urandom), $urandom, 16'($urandom), $urandom);
        else
            send_tick($urandom);
    endtask

    // Output side: random stalls and one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_output)
            out_ready <= 1'b0;
        else if (idle_enabled && $urandom_range(5) == 0)
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    // Result checking.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (!running || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WD_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Long receiver hold-off that back-pressures the block.
    initial
    begin
        hold_output = 1'b0;
        wait (running);
        repeat (3000) @(posedge clk);
        hold_output <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_output <= 1'b0;
    end

    initial
    begin
        int i;
        int s;
        sb = new();
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        idle_enabled = 1'b1;
        running      = 1'b0;
        quiet_cycles = 0;
        clock_now    = 32'd1000;
        next_seq     = 16'd100;
        next_ts      = 32'd5000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        running = 1'b1;

        // Directed: tick while prebuffering, reorder, duplicate, extremes.
        send_tick(32'hFFFF_FFFF);
        send_arrival(16'd10, 32'd0, 16'hFFFF, 32'd0);
        send_arrival(16'd5, 32'd90000, 16'h0000, 32'd10);
        send_arrival(16'd10, 32'd1, 16'h1234, 32'd20);
        send_arrival(16'hFFFF, 32'hFFFF_FFFF, 16'hA5A5, 32'd30);
        send_arrival(16'd0, 32'd180000, 16'h5A5A, 32'd40);
        send_tick(32'd50);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd0);
        drain();

        // Zero span and a limit above capacity.
        write_cfg(CFG_PREBUFFER_SPAN, 23'd0);
        write_cfg(CFG_BUFFER_LIMIT, 23'd127);
        write_cfg(4'd15, 23'h7FFFFF);
        send_arrival(16'd7, 32'hFFFF_FFF0, 16'd1, 32'h8000_0000);
        send_tick(32'h7FFF_FFFF);
        send_tick(32'h8000_0000);
        drain();

        // Limit of zero: every arrival overflows.
        write_cfg(CFG_BUFFER_LIMIT, 23'd0);
        send_arrival(16'd1, 32'd1, 16'd1, 32'd1);
        send_arrival(16'd2, 32'd2, 16'd2, 32'd2);
        drain();

        // Small limit, largest span.
        write_cfg(CFG_BUFFER_LIMIT, 23'd3);
        write_cfg(CFG_PREBUFFER_SPAN, 23'h7FFFFF);
        for (i = 0; i < 5; i++)
            send_arrival(16'(i), 32'(i) * 32'h0020_0000, 16'(i), 32'd500);
        send_tick(32'hFFFF_FFFF);
        drain();

        // Random phases under varied settings.
        for (s = 0; s < 4; s++)
        begin
            case (s)
                0:
                begin
                    write_cfg(CFG_BUFFER_LIMIT, 23'd64);
                    write_cfg(CFG_PREBUFFER_SPAN, 23'd20000);
                end
                1:
                begin
                    write_cfg(CFG_BUFFER_LIMIT, 23'd8);
                    write_cfg(CFG_PREBUFFER_SPAN, 23'd0);
                end
                2:
                begin
                    write_cfg(CFG_BUFFER_LIMIT, 23'd65);
                    write_cfg(CFG_PREBUFFER_SPAN, 23'd180000);
                end
                default:
                begin
                    write_cfg(CFG_BUFFER_LIMIT, 23'($urandom_range(1, 64)));
                    write_cfg(CFG_PREBUFFER_SPAN, 23'($urandom_range(0, 60000)));
                end
            endcase
            if (s == 3)
                idle_enabled = 1'b0;
            for (i = 0; i < 110; i++)
                random_item();
            drain();
        end

        running = 1'b0;
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
